[design/dlfe_pkg.sv]
`timescale 1ns / 1ps
package dlfe_pkg;

	localparam logic [2:0] MODE_LINE   = 3'd0;
	localparam logic [2:0] MODE_CLEAR  = 3'd1;
	localparam logic [2:0] MODE_GLYPH  = 3'd2;
	localparam logic [2:0] MODE_INVERT = 3'd3;
	localparam logic [2:0] MODE_READ   = 3'd4;

	localparam int POS_W = 24;
	localparam int DIV_STEPS = 24;
	localparam logic [7:0] FADE_OFF = 8'hFF;
	localparam logic [7:0] HALF_PIXEL = 8'h80;
	localparam logic [7:0] PIXEL_MSB = 8'h80;
	localparam logic [2:0] GLYPH_LAST = 3'd6;

	typedef struct packed {
		logic [2:0]       mode;
		logic             inverse;
		logic [7:0]       period;
		logic [15:0]      length;
		logic [POS_W-1:0] xpos;
		logic [POS_W-1:0] ypos;
		logic [POS_W-1:0] xinc;
		logic [POS_W-1:0] yinc;
		logic [12:0]      base;
		logic [5:0]       ncols;
		logic [55:0]      glyph;
		logic [12:0]      raddr;
	} cmd_t;

endpackage

[design/dlfe_ram.sv]
`timescale 1ns / 1ps
module dlfe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 6144
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[design/dlfe_queue.sv]
`timescale 1ns / 1ps
module dlfe_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  dlfe_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          avail,
	output dlfe_pkg::cmd_t head
);
	dlfe_pkg::cmd_t slot_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign avail = (cnt_q != 2'd0);
	assign head  = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wp_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) wp_q <= ~wp_q;
			if (pop && avail) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push && !full} - {1'b0, pop && avail};
		end
	end
endmodule

[design/dlfe_front.sv]
`timescale 1ns / 1ps
module dlfe_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic [2:0]    mode,
	input  logic signed [15:0] start_x,
	input  logic signed [15:0] start_y,
	input  logic signed [15:0] end_x,
	input  logic signed [15:0] end_y,
	input  logic [7:0]    fade,
	input  logic          inverse,
	input  logic [4:0]    cell_col,
	input  logic [4:0]    cell_row,
	input  logic [5:0]    cell_count,
	input  logic [55:0]   glyph_bits,
	input  logic [12:0]   read_addr,
	output logic          push,
	output dlfe_pkg::cmd_t push_cmd,
	input  logic          full
);
	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_DIV  = 2'd1;
	localparam logic [1:0] F_HOLD = 2'd2;

	logic [1:0] st_q;
	dlfe_pkg::cmd_t cmd_q;
	logic [4:0] it_q;
	logic [23:0] xdvd_q, ydvd_q, xquo_q, yquo_q;
	logic [16:0] xrem_q, yrem_q;
	logic xneg_q, yneg_q;

	logic [15:0] dx, dy, adx, ady, len;
	logic [16:0] xr_sh, yr_sh, xr_nx, yr_nx;
	logic xbit, ybit;
	logic [23:0] xq_nx, yq_nx;

	assign dx  = 16'(end_x - start_x);
	assign dy  = 16'(end_y - start_y);
	assign adx = dx[15] ? 16'(-dx) : dx;
	assign ady = dy[15] ? 16'(-dy) : dy;
	assign len = (ady < adx) ? adx : ady;

	always_comb begin
		xr_sh = {xrem_q[15:0], xdvd_q[23]};
		yr_sh = {yrem_q[15:0], ydvd_q[23]};
		xbit  = (xr_sh >= {1'b0, cmd_q.length});
		ybit  = (yr_sh >= {1'b0, cmd_q.length});
		xr_nx = xbit ? 17'(xr_sh - {1'b0, cmd_q.length}) : xr_sh;
		yr_nx = ybit ? 17'(yr_sh - {1'b0, cmd_q.length}) : yr_sh;
		xq_nx = {xquo_q[22:0], xbit};
		yq_nx = {yquo_q[22:0], ybit};
	end

	assign busy     = (st_q != F_IDLE);
	assign push     = (st_q == F_HOLD) && !full;
	assign push_cmd = cmd_q;

	always_ff @(posedge clk) begin
		if (st_q == F_IDLE && start) begin
			cmd_q.mode    <= mode;
			cmd_q.inverse <= inverse;
			cmd_q.period  <= 8'(fade + 8'd1);
			cmd_q.length  <= (fade == dlfe_pkg::FADE_OFF) ? 16'd0 : len;
			cmd_q.xpos    <= {start_x, dlfe_pkg::HALF_PIXEL};
			cmd_q.ypos    <= {start_y, dlfe_pkg::HALF_PIXEL};
			cmd_q.xinc    <= '0;
			cmd_q.yinc    <= '0;
			cmd_q.base    <= {cell_row, 8'd0} + {5'd0, cell_col, 3'd0};
			cmd_q.ncols   <= cell_count;
			cmd_q.glyph   <= glyph_bits;
			cmd_q.raddr   <= read_addr;
			xdvd_q <= {adx, 8'd0};
			ydvd_q <= {ady, 8'd0};
			xrem_q <= '0;
			yrem_q <= '0;
			xquo_q <= '0;
			yquo_q <= '0;
			xneg_q <= dx[15];
			yneg_q <= dy[15];
		end else if (st_q == F_DIV) begin
			xdvd_q <= {xdvd_q[22:0], 1'b0};
			ydvd_q <= {ydvd_q[22:0], 1'b0};
			xrem_q <= xr_nx;
			yrem_q <= yr_nx;
			xquo_q <= xq_nx;
			yquo_q <= yq_nx;
			if (it_q == 5'(dlfe_pkg::DIV_STEPS - 1)) begin
				cmd_q.xinc <= xneg_q ? 24'(-xq_nx) : xq_nx;
				cmd_q.yinc <= yneg_q ? 24'(-yq_nx) : yq_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= F_IDLE;
			it_q <= '0;
		end else begin
			case (st_q)
				F_IDLE: begin
					it_q <= '0;
					if (start) begin
						if (mode == dlfe_pkg::MODE_LINE && fade != dlfe_pkg::FADE_OFF
							&& len != 16'd0) begin
							st_q <= F_DIV;
						end else begin
							st_q <= F_HOLD;
						end
					end
				end
				F_DIV: begin
					it_q <= it_q + 5'd1;
					if (it_q == 5'(dlfe_pkg::DIV_STEPS - 1)) st_q <= F_HOLD;
				end
				F_HOLD: begin
					if (!full) st_q <= F_IDLE;
				end
				default: st_q <= F_IDLE;
			endcase
		end
	end
endmodule

[design/dlfe_back.sv]
`timescale 1ns / 1ps
module dlfe_back #(
	parameter int FB_HEIGHT = 192,
	parameter int FB_BYTES = 6144
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          avail,
	input  dlfe_pkg::cmd_t head,
	output logic          pop,
	output logic          result_valid,
	output logic [7:0]    read_data
);
	localparam int AW = $clog2(FB_BYTES);
	localparam logic [13:0] LIMIT = 14'(FB_BYTES);

	localparam logic [3:0] B_RCLR = 4'd0;
	localparam logic [3:0] B_IDLE = 4'd1;
	localparam logic [3:0] B_CLR  = 4'd2;
	localparam logic [3:0] B_LINE = 4'd3;
	localparam logic [3:0] B_LWR  = 4'd4;
	localparam logic [3:0] B_GLY  = 4'd5;
	localparam logic [3:0] B_INVR = 4'd6;
	localparam logic [3:0] B_INVW = 4'd7;
	localparam logic [3:0] B_RD   = 4'd8;
	localparam logic [3:0] B_RDW  = 4'd9;

	logic [3:0] st_q;
	dlfe_pkg::cmd_t cmd_q;
	logic [15:0] step_q;
	logic [7:0] fcnt_q, mask_q;
	logic [dlfe_pkg::POS_W-1:0] xx_q, yy_q;
	logic [2:0] k_q;
	logic [5:0] c_q;
	logic [AW-1:0] clr_q, addr_q;
	logic res_v_q;
	logic [7:0] res_d_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [7:0] wdata, rdata;
	logic [15:0] xi, yi;
	logic [13:0] line_a, gly_a, inv_a;
	logic plot;
	logic res_set;

	dlfe_ram #(.WIDTH(8), .DEPTH(FB_BYTES)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign xi = xx_q[23:8];
	assign yi = yy_q[23:8];
	assign line_a = {1'b0, yi[7:3], xi[7:3], yi[2:0]};
	assign gly_a  = {1'b0, cmd_q.base} + {11'd0, k_q};
	assign inv_a  = {1'b0, cmd_q.base} + {5'd0, c_q, 3'd0} + {11'd0, k_q};
	assign plot   = (step_q != cmd_q.length) && (fcnt_q == 8'd1) && (xi[15:8] == 8'd0)
		&& (yi < 16'(FB_HEIGHT)) && (line_a < LIMIT);
	assign pop = (st_q == B_IDLE) && avail;
	assign result_valid = res_v_q;
	assign read_data = res_d_q;

	always_comb begin
		we = 1'b0;
		waddr = addr_q;
		wdata = 8'd0;
		raddr = '0;
		case (st_q)
			B_RCLR, B_CLR: begin
				we = 1'b1;
				waddr = clr_q;
			end
			B_LINE: raddr = AW'(line_a);
			B_LWR: begin
				we = 1'b1;
				wdata = cmd_q.inverse ? (rdata & ~mask_q) : (rdata | mask_q);
			end
			B_GLY: begin
				we = (gly_a < LIMIT);
				waddr = AW'(gly_a);
				wdata = cmd_q.glyph[{k_q, 3'd0} +: 8];
			end
			B_INVR: raddr = AW'(inv_a);
			B_INVW: begin
				we = 1'b1;
				wdata = ~rdata;
			end
			B_RD: raddr = AW'(cmd_q.raddr);
			default: ;
		endcase
	end

	always_comb begin
		res_set = 1'b0;
		case (st_q)
			B_CLR: res_set = (clr_q == AW'(FB_BYTES - 1));
			B_IDLE: res_set = avail && (head.mode > dlfe_pkg::MODE_READ);
			B_LINE: res_set = (step_q == cmd_q.length);
			B_GLY: res_set = (k_q == dlfe_pkg::GLYPH_LAST);
			B_INVR: res_set = (c_q == cmd_q.ncols);
			B_RDW: res_set = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) cmd_q <= head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_RCLR;
			clr_q <= '0;
			res_v_q <= 1'b0;
			res_d_q <= '0;
			step_q <= '0;
			fcnt_q <= '0;
			mask_q <= '0;
			xx_q <= '0;
			yy_q <= '0;
			k_q <= '0;
			c_q <= '0;
			addr_q <= '0;
		end else begin
			res_v_q <= res_set;
			case (st_q)
				B_RCLR, B_CLR: begin
					if (clr_q == AW'(FB_BYTES - 1)) begin
						clr_q <= '0;
						res_d_q <= '0;
						st_q <= B_IDLE;
					end else begin
						clr_q <= clr_q + AW'(1);
					end
				end
				B_IDLE: begin
					if (avail) begin
						step_q <= '0;
						fcnt_q <= head.period;
						xx_q <= head.xpos;
						yy_q <= head.ypos;
						k_q <= '0;
						c_q <= '0;
						case (head.mode)
							dlfe_pkg::MODE_LINE:   st_q <= B_LINE;
							dlfe_pkg::MODE_CLEAR:  st_q <= B_CLR;
							dlfe_pkg::MODE_GLYPH:  st_q <= B_GLY;
							dlfe_pkg::MODE_INVERT: st_q <= B_INVR;
							dlfe_pkg::MODE_READ:   st_q <= B_RD;
							default: res_d_q <= '0;
						endcase
					end
				end
				B_LINE: begin
					if (step_q == cmd_q.length) begin
						res_d_q <= '0;
						st_q <= B_IDLE;
					end else begin
						step_q <= step_q + 16'd1;
						xx_q <= xx_q + cmd_q.xinc;
						yy_q <= yy_q + cmd_q.yinc;
						fcnt_q <= (fcnt_q == 8'd1) ? cmd_q.period : fcnt_q - 8'd1;
						addr_q <= AW'(line_a);
						mask_q <= dlfe_pkg::PIXEL_MSB >> xi[2:0];
						if (plot) st_q <= B_LWR;
					end
				end
				B_LWR: st_q <= B_LINE;
				B_GLY: begin
					k_q <= k_q + 3'd1;
					if (k_q == dlfe_pkg::GLYPH_LAST) begin
						res_d_q <= '0;
						st_q <= B_IDLE;
					end
				end
				B_INVR: begin
					if (c_q == cmd_q.ncols) begin
						res_d_q <= '0;
						st_q <= B_IDLE;
					end else begin
						addr_q <= AW'(inv_a);
						if (k_q == dlfe_pkg::GLYPH_LAST) begin
							k_q <= '0;
							c_q <= c_q + 6'd1;
						end else begin
							k_q <= k_q + 3'd1;
						end
						if (inv_a < LIMIT) st_q <= B_INVW;
					end
				end
				B_INVW: st_q <= B_INVR;
				B_RD: st_q <= B_RDW;
				B_RDW: begin
					res_d_q <= ({1'b0, cmd_q.raddr} < LIMIT) ? rdata : 8'd0;
					st_q <= B_IDLE;
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> ({1'b0, waddr} < LIMIT))
		else $error("store write beyond end");
	a_res_after_op: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ($past(st_q) != B_RCLR && $past(st_q) != B_LWR
			&& $past(st_q) != B_INVW))
		else $error("result from a non-final state");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (st_q != B_IDLE || result_valid))
		else $error("request popped but not started");
endmodule

[design/dda_line_framebuffer_engine_core.sv]
`timescale 1ns / 1ps
// Line, glyph and cell engine over a 1-bit 256-pixel-wide framebuffer
// with an 8x8 cell interleave.
// A request is taken when start is high and busy is low; all request
// fields are sampled at that edge. Each request yields one result: a
// single-cycle result_valid pulse with read_data (the byte for a read,
// zero for other modes). The receiver cannot stall the block.
// The front accepts a request and, for a line with nonzero length and
// fade not 8'hFF, runs two parallel 24-step restoring divisions for the
// axis increments, then hands it to a two-entry queue; busy is high
// while the front works. The back executes requests in order against a
// single-port-write, registered-read store: a line steps its length,
// reading and writing each plotted pixel's byte; clear zeroes every
// byte; glyph writes 7 bytes; invert reads and writes each in-range
// byte, 7 per cell. The result is registered as the operation ends.
// After reset the back sweeps the store to zero before it starts queued
// requests; the front still accepts them.
module dda_line_framebuffer_engine_core #(
	parameter int FB_HEIGHT = 192,
	parameter int FB_BYTES = 6144
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         mode,
	input  logic signed [15:0] start_x,
	input  logic signed [15:0] start_y,
	input  logic signed [15:0] end_x,
	input  logic signed [15:0] end_y,
	input  logic [7:0]         fade,
	input  logic               inverse,
	input  logic [4:0]         cell_col,
	input  logic [4:0]         cell_row,
	input  logic [5:0]         cell_count,
	input  logic [55:0]        glyph_bits,
	input  logic [12:0]        read_addr,
	output logic               result_valid,
	output logic [7:0]         read_data
);
	logic push, full, pop, avail;
	dlfe_pkg::cmd_t push_cmd, head;

	dlfe_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
		.fade(fade), .inverse(inverse), .cell_col(cell_col), .cell_row(cell_row),
		.cell_count(cell_count), .glyph_bits(glyph_bits), .read_addr(read_addr),
		.push(push), .push_cmd(push_cmd), .full(full)
	);

	dlfe_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_cmd(push_cmd), .full(full),
		.pop(pop), .avail(avail), .head(head)
	);

	dlfe_back #(.FB_HEIGHT(FB_HEIGHT), .FB_BYTES(FB_BYTES)) u_back (
		.clk(clk), .arst_n(arst_n), .avail(avail), .head(head), .pop(pop),
		.result_valid(result_valid), .read_data(read_data)
	);
endmodule

[tb/dda_line_framebuffer_engine_core_tb.sv]
`timescale 1ns / 1ps
module dda_line_framebuffer_engine_core_tb;

	localparam int FB_H = 192;
	localparam int FB_SIZE = 6144;
	localparam logic [2:0] MODE_TOP = 3'd7;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [2:0]         mode;
	logic signed [15:0] start_x;
	logic signed [15:0] start_y;
	logic signed [15:0] end_x;
	logic signed [15:0] end_y;
	logic [7:0]         fade;
	logic               inverse;
	logic [4:0]         cell_col;
	logic [4:0]         cell_row;
	logic [5:0]         cell_count;
	logic [55:0]        glyph_bits;
	logic [12:0]        read_addr;
	logic               result_valid;
	logic [7:0]         read_data;

	logic [7:0] frame_bytes [0:FB_SIZE-1];
	logic [7:0] pending_bytes [$];
	logic [12:0] touched [$];
	int fail_count;
	bit no_gaps;

	dda_line_framebuffer_engine_core #(.FB_HEIGHT(FB_H), .FB_BYTES(FB_SIZE)) dut (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic void note_touch(int unsigned a);
		touched.push_back(a[12:0]);
		if (touched.size() > 256)
			void'(touched.pop_front());
	endfunction

	function automatic int unsigned axis_inc(int unsigned d, int unsigned len);
		bit neg;
		int unsigned mag;
		int unsigned q;
		neg = d[15];
		mag = neg ? ((32'h10000 - d) & 32'h1FFFF) : d;
		q = (mag << 8) / len;
		return neg ? (32'd0 - q) : q;
	endfunction

	function automatic void model_line(logic [15:0] x0, logic [15:0] y0, logic [15:0] x1,
			logic [15:0] y1, logic [7:0] fd, logic inv);
		int unsigned period, dx, dy, adx, ady, len, xinc, yinc, xx, yy, cnt, xi, yi, a;
		logic [7:0] m;
		period = fd + 1;
		dx = (x1 - x0) & 32'hFFFF;
		dy = (y1 - y0) & 32'hFFFF;
		adx = dx[15] ? (32'h10000 - dx) : dx;
		ady = dy[15] ? (32'h10000 - dy) : dy;
		len = (ady < adx) ? adx : ady;
		if (period > 255 || len == 0)
			return;
		xinc = axis_inc(dx, len);
		yinc = axis_inc(dy, len);
		xx = ({{16{x0[15]}}, x0} << 8) | 32'h80;
		yy = ({{16{y0[15]}}, y0} << 8) | 32'h80;
		cnt = period;
		for (int unsigned i = 0; i < len; i++) begin
			cnt--;
			if (cnt == 0) begin
				xi = (xx >> 8) & 32'hFFFF;
				yi = (yy >> 8) & 32'hFFFF;
				cnt = period;
				if (xi < 256 && yi < FB_H) begin
					a = ((yi >> 3) << 8) + (yi & 7) + (xi & 32'hF8);
					m = 8'h80 >> (xi & 7);
					if (a < FB_SIZE) begin
						frame_bytes[a] = inv ? (frame_bytes[a] & ~m) : (frame_bytes[a] | m);
						note_touch(a);
					end
				end
			end
			xx += xinc;
			yy += yinc;
		end
	endfunction

	function automatic logic [7:0] model_request(logic [2:0] m, logic [15:0] x0, logic [15:0] y0,
			logic [15:0] x1, logic [15:0] y1, logic [7:0] fd, logic inv, logic [4:0] col,
			logic [4:0] row, logic [5:0] cnt, logic [55:0] g, logic [12:0] ra);
		int unsigned base, a;
		base = (row << 8) + (col << 3);
		case (m)
			dlfe_pkg::MODE_LINE: model_line(x0, y0, x1, y1, fd, inv);
			dlfe_pkg::MODE_CLEAR: foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
			dlfe_pkg::MODE_GLYPH: for (int k = 0; k < 7; k++) begin
				a = base + k;
				if (a < FB_SIZE) begin
					frame_bytes[a] = g[8*k +: 8];
					note_touch(a);
				end
			end
			dlfe_pkg::MODE_INVERT: for (int c = 0; c < cnt; c++)
				for (int k = 0; k < 7; k++) begin
					a = base + c * 8 + k;
					if (a < FB_SIZE) begin
						frame_bytes[a] = ~frame_bytes[a];
						note_touch(a);
					end
				end
			dlfe_pkg::MODE_READ: if (ra < FB_SIZE)
				return frame_bytes[ra];
			default: ;
		endcase
		return 8'h00;
	endfunction

	task automatic send_request(logic [2:0] m, logic [15:0] x0, logic [15:0] y0, logic [15:0] x1,
			logic [15:0] y1, logic [7:0] fd, logic inv, logic [4:0] col, logic [4:0] row,
			logic [5:0] cnt, logic [55:0] g, logic [12:0] ra);
		int gap;
		mode <= m;
		start_x <= x0;
		start_y <= y0;
		end_x <= x1;
		end_y <= y1;
		fade <= fd;
		inverse <= inv;
		cell_col <= col;
		cell_row <= row;
		cell_count <= cnt;
		glyph_bits <= g;
		read_addr <= ra;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		pending_bytes.push_back(model_request(m, x0, y0, x1, y1, fd, inv, col, row, cnt, g, ra));
		if ($urandom_range(0, 49) == 0)
			no_gaps = ~no_gaps;
		gap = 0;
		if (!no_gaps) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: gap = 0;
				5, 6, 7, 8: gap = $urandom_range(1, 3);
				default: gap = $urandom_range(10, 40);
			endcase
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_line(int x0, int y0, int x1, int y1, logic [7:0] fd, logic inv);
		send_request(dlfe_pkg::MODE_LINE, x0[15:0], y0[15:0], x1[15:0], y1[15:0], fd, inv,
			$urandom, $urandom, $urandom, {$urandom, $urandom}, $urandom);
	endtask

	task automatic send_read(logic [12:0] a);
		send_request(dlfe_pkg::MODE_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom, {$urandom, $urandom}, a);
	endtask

	task automatic send_cells(logic [2:0] m, logic [4:0] col, logic [4:0] row, logic [5:0] cnt,
			logic [55:0] g);
		send_request(m, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			col, row, cnt, g, $urandom);
	endtask

	task automatic read_touched(int n);
		for (int i = 0; i < n && touched.size() > 0; i++)
			send_read(touched[$urandom_range(0, touched.size() - 1)]);
	endtask

	always @(posedge clk) begin
		if (result_valid) begin
			if (pending_bytes.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual read_data %02h",
					$time, read_data);
				fail_count++;
			end else if (read_data !== pending_bytes[0]) begin
				$display("%0t: read_data mismatch, expected %02h, actual %02h",
					$time, pending_bytes[0], read_data);
				fail_count++;
				void'(pending_bytes.pop_front());
			end else begin
				void'(pending_bytes.pop_front());
			end
		end
	end

	task automatic test_lines;
		send_line(10, 10, 60, 10, 8'd0, 1'b0);
		send_line(20, 5, 20, 90, 8'd0, 1'b0);
		send_line(100, 100, 40, 40, 8'd2, 1'b0);
		send_line(250, 3, 3, 180, 8'd0, 1'b0);
		send_line(30, 30, 30, 30, 8'd0, 1'b0);
		send_line(0, 0, 255, 191, 8'd255, 1'b0);
		send_line(-20, -20, 300, 220, 8'd0, 1'b0);
		send_line(60, 10, 10, 10, 8'd0, 1'b1);
		send_line(-32768, 0, 32767, 0, 8'd0, 1'b0);
		send_line(-32768, 100, 0, 100, 8'd254, 1'b0);
		send_line(0, 191, 300, 191, 8'd1, 1'b0);
		read_touched(14);
	endtask

	task automatic test_cells;
		send_cells(dlfe_pkg::MODE_GLYPH, 5'd0, 5'd0, 6'd0, 56'hA5_5A_FF_00_81_42_3C);
		send_cells(dlfe_pkg::MODE_GLYPH, 5'd31, 5'd23, 6'd0, 56'hFF_FF_FF_FF_FF_FF_FF);
		send_cells(dlfe_pkg::MODE_GLYPH, 5'd31, 5'd31, 6'd0, 56'h12_34_56_78_9A_BC_DE);
		send_cells(dlfe_pkg::MODE_INVERT, 5'd0, 5'd0, 6'd32, 56'd0);
		send_cells(dlfe_pkg::MODE_INVERT, 5'd20, 5'd23, 6'd63, 56'd0);
		send_cells(dlfe_pkg::MODE_INVERT, 5'd3, 5'd2, 6'd0, 56'd0);
		read_touched(12);
		send_read(13'd0);
		send_read(13'd6143);
		send_read(13'd6144);
		send_read(13'd8191);
	endtask

	task automatic test_modes;
		for (logic [3:0] m = dlfe_pkg::MODE_READ + 1; m <= MODE_TOP; m++)
			send_request(m[2:0], $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, {$urandom, $urandom}, 13'd0);
		send_cells(dlfe_pkg::MODE_CLEAR, $urandom, $urandom, $urandom, {$urandom, $urandom});
		send_read(13'd0);
		send_read(13'd6143);
	endtask

	task automatic test_random(int n);
		int x0, y0, dxr, dyr, sel;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 199);
			if (sel < 90) begin
				x0 = $urandom_range(0, 287) - 16;
				y0 = $urandom_range(0, 223) - 16;
				dxr = ($urandom_range(0, 3) == 0) ? 300 : 40;
				dyr = ($urandom_range(0, 3) == 0) ? 220 : 40;
				send_line(x0, y0, x0 + $urandom_range(0, 2 * dxr) - dxr,
					y0 + $urandom_range(0, 2 * dyr) - dyr, $urandom_range(0, 9) == 0 ?
					$urandom : $urandom_range(0, 3), $urandom_range(0, 3) == 0);
			end else if (sel < 98) begin
				x0 = $urandom;
				y0 = $urandom;
				send_line(x0, y0, x0 + $urandom_range(0, 40) - 20, y0 + $urandom_range(0, 40) - 20,
					$urandom, $urandom);
			end else if (sel < 99) begin
				send_line($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 3), $urandom);
			end else if (sel < 170) begin
				if ($urandom_range(0, 3) != 0 && touched.size() > 0)
					read_touched(1);
				else
					send_read($urandom);
			end else if (sel < 182) begin
				send_cells(dlfe_pkg::MODE_GLYPH, $urandom, $urandom_range(0, 9) == 0 ? $urandom :
					$urandom_range(0, 23), $urandom, {$urandom, $urandom});
			end else if (sel < 194) begin
				send_cells(dlfe_pkg::MODE_INVERT, $urandom, $urandom_range(0, 9) == 0 ? $urandom :
					$urandom_range(0, 23), $urandom_range(0, 9) == 0 ? $urandom :
					$urandom_range(0, 4), {$urandom, $urandom});
			end else if (sel < 197) begin
				send_cells(dlfe_pkg::MODE_CLEAR, $urandom, $urandom, $urandom,
					{$urandom, $urandom});
			end else begin
				send_request(3'($urandom_range(dlfe_pkg::MODE_READ + 1, MODE_TOP)), $urandom,
					$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, {$urandom, $urandom}, $urandom);
			end
		end
	endtask

	initial begin
		int guard;
		fail_count = 0;
		no_gaps = 1'b0;
		foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
		arst_n = 1'b0;
		start = 1'b0;
		mode = dlfe_pkg::MODE_READ;
		start_x = '0;
		start_y = '0;
		end_x = '0;
		end_y = '0;
		fade = '0;
		inverse = 1'b0;
		cell_col = '0;
		cell_row = '0;
		cell_count = '0;
		glyph_bits = '0;
		read_addr = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_lines();
		test_cells();
		test_modes();
		test_random(1220);
		start <= 1'b0;
		guard = 0;
		while (pending_bytes.size() > 0 && guard < 2_000_000) begin
			@(posedge clk);
			guard++;
		end
		if (pending_bytes.size() > 0) begin
			$display("%0t: %0d results never arrived, expected first %02h", $time,
				pending_bytes.size(), pending_bytes[0]);
			fail_count++;
		end
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
